FILE: hw/rtl/srdt_pkg.sv
// Types and constants shared by the scan report device table.
// Used by scan_report_device_table_top and the bench tb_top.
`timescale 1ns / 1ps
package srdt_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH0,
      ST_SRCH,
      ST_HRD,
      ST_HUPD,
      ST_PAY,
      ST_SVC0,
      ST_SVC,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_LEN,
      PH_TYPE,
      PH_SKIP,
      PH_FIRST,
      PH_SVC_LO,
      PH_SVC_HI,
      PH_NAME,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      OC_KNOWN   = 3'd0,
      OC_NEW     = 3'd1,
      OC_FULL    = 3'd2,
      OC_USED    = 3'd3,
      OC_IGNORED = 3'd4
   } outcome_type;

   typedef struct packed {
      logic              addr_kind;
      logic [2:0]        event_kind;
      logic signed [7:0] last;
      logic signed [7:0] avg;
      logic [15:0]       sightings;
      logic [7:0]        flags;
      logic signed [7:0] power;
      logic [4:0]        svc_total;
      logic [7:0]        name_size;
   } rec_type;

   localparam logic [7:0] AD_FLAGS      = 8'h01;
   localparam logic [7:0] AD_SVC_PART   = 8'h02;
   localparam logic [7:0] AD_SVC_FULL   = 8'h03;
   localparam logic [7:0] AD_NAME_SHORT = 8'h08;
   localparam logic [7:0] AD_NAME_FULL  = 8'h09;
   localparam logic [7:0] AD_TX_POWER   = 8'h0A;

   localparam logic signed [7:0] POWER_UNKNOWN = 8'sd127;
   localparam logic [15:0]       SIGHT_MAX     = 16'hFFFF;
   // 205/1024 approximates 1/5 exactly for magnitudes up to 640
   localparam logic [7:0]        DIV5_RECIP    = 8'd205;

endpackage

FILE: hw/rtl/scan_report_device_table_top.sv
// Scan report device table: address search, strength smoothing, AD parser.
// Depends on srdt_pkg and srdt_ram.
`timescale 1ns / 1ps
//
//  channel  valid/ready          payload
//  req      req_valid/req_ready  req_action .. req_payload_byte
//  rsp      rsp_valid/rsp_ready  rsp_entry_index .. rsp_name_length
//
// Header: the search makes one address RAM read per cycle through the shared
// compare, so its length follows the number of entries searched.
// Payload byte: steps PAY and OUT, with SVC0 and SVC between for a service search.
// One item at a time; req_ready is low until the result is loaded.
// A stalled rsp holds the block in its output step.
// No clearing pass after reset: the fill count guards every table read.
module scan_report_device_table_top #(
   parameter int TABLE_ENTRIES = 64,
   parameter int SERVICE_SLOTS = 8,
   parameter int NAME_BYTES    = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [47:0]       req_device_address,
   input  logic              req_address_type,
   input  logic [2:0]        req_event_type,
   input  logic signed [7:0] req_signal_strength,
   input  logic [4:0]        req_payload_length,
   input  logic [7:0]        req_payload_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [5:0]        rsp_entry_index,
   output logic [2:0]        rsp_outcome,
   output logic signed [7:0] rsp_average_strength,
   output logic signed [7:0] rsp_last_strength,
   output logic [15:0]       rsp_sighting_count,
   output logic [6:0]        rsp_devices_known,
   output logic [7:0]        rsp_entry_flags,
   output logic signed [7:0] rsp_entry_tx_power,
   output logic [3:0]        rsp_service_count,
   output logic [5:0]        rsp_name_length
);

   localparam int IW  = $clog2(TABLE_ENTRIES);
   localparam int CW  = $clog2(TABLE_ENTRIES + 1);
   localparam int KW  = $clog2(SERVICE_SLOTS + 1);
   localparam int SAW = $clog2(TABLE_ENTRIES * SERVICE_SLOTS);
   localparam int RW  = $bits(srdt_pkg::rec_type);

   srdt_pkg::state_type   state_ff, state_in;
   srdt_pkg::phase_type   phase_ff, phase_in;
   srdt_pkg::outcome_type outcome_ff, outcome_in;
   srdt_pkg::rec_type     cur_rec_ff, cur_rec_in, rec_rd, base_rec;

   logic [CW-1:0]  occ_ff, occ_in, scan_ff, scan_in;
   logic [IW-1:0]  hit_ff, hit_in, cur_ff, cur_in;
   logic           new_ff, new_in, valid_ff, valid_in;
   logic [4:0]     pos_ff, pos_in, total_ff, total_in, rem_ff, rem_in;
   logic [7:0]     stype_ff, stype_in, held_ff, held_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [15:0]    uuid_ff, uuid_in;

   logic [47:0]       addr_ff;
   logic              atype_ff;
   logic [2:0]        etype_ff;
   logic signed [7:0] strength_ff;
   logic [4:0]        len_ff;
   logic [7:0]        byte_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        o_index_ff;
   logic [2:0]        o_outcome_ff;
   logic [6:0]        o_known_ff;
   srdt_pkg::rec_type o_rec_ff;

   logic           adr_we, rec_we, svc_we;
   logic [IW-1:0]  adr_rd_addr;
   logic [47:0]    adr_rd_data;
   logic [RW-1:0]  rec_rd_data;
   logic [SAW-1:0] svc_base, svc_rd_addr, svc_wr_addr;
   logic [15:0]    svc_rd_data;
   logic           load_out;

   logic signed [10:0] avg_sum;
   logic [10:0]        avg_mag;
   logic [18:0]        avg_prod;
   logic signed [7:0]  avg_q;
   logic [8:0]         pos_next_sum, pos_len_sum;

   srdt_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES)) u_adr_ram (
      .clock   (clock),
      .wr_en   (adr_we),
      .wr_addr (occ_ff[IW-1:0]),
      .wr_data (addr_ff),
      .rd_addr (adr_rd_addr),
      .rd_data (adr_rd_data)
   );

   srdt_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (cur_ff),
      .wr_data (cur_rec_ff),
      .rd_addr (hit_ff),
      .rd_data (rec_rd_data)
   );

   srdt_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES * SERVICE_SLOTS)) u_svc_ram (
      .clock   (clock),
      .wr_en   (svc_we),
      .wr_addr (svc_wr_addr),
      .wr_data (uuid_ff),
      .rd_addr (svc_rd_addr),
      .rd_data (svc_rd_data)
   );

   assign rec_rd      = srdt_pkg::rec_type'(rec_rd_data);
   assign svc_base    = SAW'(cur_ff) * SAW'(SERVICE_SLOTS);
   assign svc_wr_addr = svc_base + SAW'(cur_rec_ff.svc_total);
   assign adr_rd_addr = (state_ff == srdt_pkg::ST_SRCH) ? IW'(scan_ff + CW'(1)) : '0;
   assign svc_rd_addr = (state_ff == srdt_pkg::ST_SVC) ?
                        svc_base + SAW'(k_ff) + SAW'(1) : svc_base;

   // fresh entry or stored record, then smoothing: trunc((4*avg+s)/5)
   always_comb begin
      base_rec = rec_rd;
      if (new_ff) begin
         base_rec           = '0;
         base_rec.addr_kind = atype_ff;
         base_rec.power     = srdt_pkg::POWER_UNKNOWN;
      end
      avg_sum  = 11'(base_rec.avg) * 11'sd4 + 11'(strength_ff);
      avg_mag  = avg_sum[10] ? 11'(-avg_sum) : 11'(avg_sum);
      avg_prod = 19'(avg_mag) * 19'(srdt_pkg::DIV5_RECIP);
      avg_q    = 8'(avg_sum[10] ? -$signed({1'b0, avg_prod[17:10]})
                                : $signed({1'b0, avg_prod[17:10]}));
      pos_next_sum = 9'(pos_ff) + 9'd1;
      pos_len_sum  = 9'(pos_ff) + 9'(byte_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srdt_pkg::ST_IDLE;
         phase_ff     <= srdt_pkg::PH_LEN;
         occ_ff       <= '0;
         cur_ff       <= '0;
         valid_ff     <= 1'b0;
         pos_ff       <= '0;
         total_ff     <= '0;
         rem_ff       <= '0;
         stype_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         occ_ff       <= occ_in;
         cur_ff       <= cur_in;
         valid_ff     <= valid_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         rem_ff       <= rem_in;
         stype_ff     <= stype_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      outcome_ff <= outcome_in;
      cur_rec_ff <= cur_rec_in;
      scan_ff    <= scan_in;
      hit_ff     <= hit_in;
      new_ff     <= new_in;
      k_ff       <= k_in;
      uuid_ff    <= uuid_in;
      if (req_valid && req_ready) begin
         addr_ff     <= req_device_address;
         atype_ff    <= req_address_type;
         etype_ff    <= req_event_type;
         strength_ff <= req_signal_strength;
         len_ff      <= req_payload_length;
         byte_ff     <= req_payload_byte;
      end
      if (load_out) begin
         o_outcome_ff <= outcome_ff;
         o_known_ff   <= 7'(occ_ff);
         o_index_ff   <= valid_ff ? 6'(cur_ff) : 6'd0;
         o_rec_ff     <= valid_ff ? cur_rec_ff : '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      outcome_in   = outcome_ff;
      cur_rec_in   = cur_rec_ff;
      occ_in       = occ_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      new_in       = new_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      stype_in     = stype_ff;
      held_in      = held_ff;
      k_in         = k_ff;
      uuid_in      = uuid_ff;
      adr_we       = 1'b0;
      rec_we       = 1'b0;
      svc_we       = 1'b0;
      load_out     = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         srdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = req_action ? srdt_pkg::ST_PAY : srdt_pkg::ST_SRCH0;
            end
         end
         srdt_pkg::ST_SRCH0: begin
            scan_in  = '0;
            state_in = srdt_pkg::ST_SRCH;
         end
         srdt_pkg::ST_SRCH: begin
            priority if (scan_ff >= occ_ff) begin
               if (occ_ff >= CW'(TABLE_ENTRIES)) begin
                  outcome_in = srdt_pkg::OC_FULL;
                  valid_in   = 1'b0;
                  cur_in     = '0;
                  phase_in   = srdt_pkg::PH_DONE;
                  pos_in     = '0;
                  total_in   = '0;
                  state_in   = srdt_pkg::ST_OUT;
               end else begin
                  hit_in   = occ_ff[IW-1:0];
                  new_in   = 1'b1;
                  adr_we   = 1'b1;
                  occ_in   = occ_ff + CW'(1);
                  state_in = srdt_pkg::ST_HUPD;
               end
            end else if (adr_rd_data == addr_ff) begin
               hit_in   = scan_ff[IW-1:0];
               new_in   = 1'b0;
               state_in = srdt_pkg::ST_HRD;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         srdt_pkg::ST_HRD: begin
            state_in = srdt_pkg::ST_HUPD;
         end
         srdt_pkg::ST_HUPD: begin
            cur_rec_in            = base_rec;
            cur_rec_in.event_kind = etype_ff;
            cur_rec_in.last       = strength_ff;
            cur_rec_in.avg        = (base_rec.sightings == '0) ? strength_ff : avg_q;
            if (base_rec.sightings != srdt_pkg::SIGHT_MAX) begin
               cur_rec_in.sightings = base_rec.sightings + 16'd1;
            end
            outcome_in = new_ff ? srdt_pkg::OC_NEW : srdt_pkg::OC_KNOWN;
            cur_in     = hit_ff;
            valid_in   = 1'b1;
            total_in   = len_ff;
            pos_in     = '0;
            phase_in   = srdt_pkg::PH_LEN;
            rem_in     = '0;
            stype_in   = '0;
            held_in    = '0;
            state_in   = srdt_pkg::ST_OUT;
         end
         srdt_pkg::ST_PAY: begin
            state_in   = srdt_pkg::ST_OUT;
            outcome_in = srdt_pkg::OC_IGNORED;
            if (valid_ff && pos_ff < total_ff && phase_ff != srdt_pkg::PH_DONE) begin
               pos_in     = pos_ff + 5'd1;
               outcome_in = srdt_pkg::OC_USED;
               if (phase_ff == srdt_pkg::PH_LEN) begin
                  if (pos_next_sum >= 9'(total_ff) || byte_ff == 8'd0 ||
                      pos_len_sum >= 9'(total_ff)) begin
                     phase_in   = srdt_pkg::PH_DONE;
                     outcome_in = srdt_pkg::OC_IGNORED;
                  end else begin
                     rem_in   = 5'(byte_ff - 8'd1);
                     phase_in = srdt_pkg::PH_TYPE;
                  end
               end else if (phase_ff == srdt_pkg::PH_TYPE) begin
                  stype_in = byte_ff;
                  priority if (rem_ff == '0) begin
                     phase_in = srdt_pkg::PH_LEN;
                  end else if (byte_ff == srdt_pkg::AD_FLAGS ||
                               byte_ff == srdt_pkg::AD_TX_POWER) begin
                     phase_in = srdt_pkg::PH_FIRST;
                  end else if (byte_ff == srdt_pkg::AD_SVC_PART ||
                               byte_ff == srdt_pkg::AD_SVC_FULL) begin
                     phase_in = srdt_pkg::PH_SVC_LO;
                  end else if ((byte_ff == srdt_pkg::AD_NAME_SHORT &&
                                cur_rec_ff.name_size == '0) ||
                               byte_ff == srdt_pkg::AD_NAME_FULL) begin
                     cur_rec_in.name_size = '0;
                     phase_in             = srdt_pkg::PH_NAME;
                  end else begin
                     phase_in = srdt_pkg::PH_SKIP;
                  end
               end else begin
                  priority case (phase_ff)
                     srdt_pkg::PH_FIRST: begin
                        if (stype_ff == srdt_pkg::AD_FLAGS) begin
                           cur_rec_in.flags = byte_ff;
                        end else begin
                           cur_rec_in.power = byte_ff;
                        end
                        phase_in = srdt_pkg::PH_SKIP;
                     end
                     srdt_pkg::PH_SVC_LO: begin
                        held_in  = byte_ff;
                        phase_in = srdt_pkg::PH_SVC_HI;
                     end
                     srdt_pkg::PH_SVC_HI: begin
                        uuid_in  = {byte_ff, held_ff};
                        phase_in = srdt_pkg::PH_SVC_LO;
                        if (cur_rec_ff.svc_total < 5'(SERVICE_SLOTS)) begin
                           state_in = srdt_pkg::ST_SVC0;
                        end
                     end
                     srdt_pkg::PH_NAME: begin
                        if (cur_rec_ff.name_size < 8'(NAME_BYTES)) begin
                           cur_rec_in.name_size = cur_rec_ff.name_size + 8'd1;
                        end
                     end
                     default: begin
                     end
                  endcase
                  if (rem_ff <= 5'd1) begin
                     rem_in   = '0;
                     phase_in = srdt_pkg::PH_LEN;
                  end else begin
                     rem_in = rem_ff - 5'd1;
                  end
               end
            end
         end
         srdt_pkg::ST_SVC0: begin
            k_in     = '0;
            state_in = srdt_pkg::ST_SVC;
         end
         srdt_pkg::ST_SVC: begin
            priority if (5'(k_ff) >= cur_rec_ff.svc_total) begin
               svc_we               = 1'b1;
               cur_rec_in.svc_total = cur_rec_ff.svc_total + 5'd1;
               state_in             = srdt_pkg::ST_OUT;
            end else if (svc_rd_data == uuid_ff) begin
               state_in = srdt_pkg::ST_OUT;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         srdt_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rec_we       = valid_ff;
               rsp_valid_in = 1'b1;
               state_in     = srdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srdt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entry_index      = o_index_ff;
   assign rsp_outcome          = o_outcome_ff;
   assign rsp_average_strength = o_rec_ff.avg;
   assign rsp_last_strength    = o_rec_ff.last;
   assign rsp_sighting_count   = o_rec_ff.sightings;
   assign rsp_devices_known    = o_known_ff;
   assign rsp_entry_flags      = o_rec_ff.flags;
   assign rsp_entry_tx_power   = o_rec_ff.power;
   assign rsp_service_count    = 4'(o_rec_ff.svc_total);
   assign rsp_name_length      = 6'(o_rec_ff.name_size);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a second item while busy");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == srdt_pkg::OC_FULL) |->
      (rsp_entry_index == 6'd0 && rsp_sighting_count == 16'd0))
      else $error("table full result carries entry data");

   a_new_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == srdt_pkg::OC_NEW) |->
      (rsp_sighting_count == 16'd1 && rsp_average_strength == rsp_last_strength))
      else $error("new entry not seeded from first sample");

   a_svc_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> cur_rec_ff.svc_total <= 5'(SERVICE_SLOTS))
      else $error("service count beyond slots");

endmodule

FILE: hw/rtl/srdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module srdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for scan_report_device_table_top: directed and random reports.
// Holds its own table and parser prediction; depends on srdt_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;

   localparam int ENTRIES = 64;
   localparam int SLOTS   = 8;
   localparam int NAME_MAX = 63;
   localparam int PAY_MAX = 31;

   typedef struct {
      logic [5:0]            idx;
      srdt_pkg::outcome_type oc;
      logic [7:0]            avg;
      logic [7:0]            last;
      logic [15:0]           sight;
      logic [6:0]            known;
      logic [7:0]            flags;
      logic [7:0]            power;
      logic [3:0]            svcs;
      logic [5:0]            name_len;
   } sighting_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_action = 0;
   logic [47:0] req_device_address = '0;
   logic req_address_type = 0;
   logic [2:0] req_event_type = '0;
   logic signed [7:0] req_signal_strength = '0;
   logic [4:0] req_payload_length = '0;
   logic [7:0] req_payload_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [5:0] rsp_entry_index;
   logic [2:0] rsp_outcome;
   logic signed [7:0] rsp_average_strength;
   logic signed [7:0] rsp_last_strength;
   logic [15:0] rsp_sighting_count;
   logic [6:0] rsp_devices_known;
   logic [7:0] rsp_entry_flags;
   logic signed [7:0] rsp_entry_tx_power;
   logic [3:0] rsp_service_count;
   logic [5:0] rsp_name_length;

   scan_report_device_table_top i_dut (.*);

   always #2 clock = ~clock;

   // predicted table and parser state
   int          known_devices;
   logic [47:0] dev_addr [ENTRIES];
   logic signed [7:0] dev_avg [ENTRIES];
   logic signed [7:0] dev_last [ENTRIES];
   logic [15:0] dev_sight [ENTRIES];
   logic [7:0]  dev_flags [ENTRIES];
   logic [7:0]  dev_power [ENTRIES];
   logic [15:0] dev_svc [ENTRIES][SLOTS];
   int          dev_svc_n [ENTRIES];
   int          dev_name_n [ENTRIES];
   int          cur_dev;
   bit          cur_ok;
   int          pos, pay_total, remaining;
   srdt_pkg::phase_type phase;
   logic [7:0]  ad_type, low_byte;

   sighting_type pending[$];
   bit          failed = 0;
   bit          quiet = 0;
   int          rx_stall = 0;
   int          seen_results = 0;
   int          n_items = 0, n_results = 0, n_full = 0, n_used = 0;
   logic [47:0] addr_pool[$];

   function automatic sighting_type snapshot(srdt_pkg::outcome_type oc);
      sighting_type s;
      s = '{idx: 0, oc: oc, avg: 0, last: 0, sight: 0, known: known_devices[6:0],
            flags: 0, power: 0, svcs: 0, name_len: 0};
      if (cur_ok) begin
         s.idx = cur_dev[5:0];
         s.avg = dev_avg[cur_dev];
         s.last = dev_last[cur_dev];
         s.sight = dev_sight[cur_dev];
         s.flags = dev_flags[cur_dev];
         s.power = dev_power[cur_dev];
         s.svcs = dev_svc_n[cur_dev][3:0];
         s.name_len = dev_name_n[cur_dev][5:0];
      end
      return s;
   endfunction

   function automatic srdt_pkg::outcome_type track_header(logic [47:0] a,
                                                          logic signed [7:0] ss,
                                                          logic [4:0] len);
      int e;
      srdt_pkg::outcome_type oc;
      e = -1;
      oc = srdt_pkg::OC_KNOWN;
      for (int i = 0; i < known_devices; i++)
         if (e < 0 && dev_addr[i] == a) e = i;
      if (e < 0) begin
         if (known_devices >= ENTRIES) begin
            cur_ok = 0; cur_dev = 0; phase = srdt_pkg::PH_DONE; pos = 0; pay_total = 0;
            return srdt_pkg::OC_FULL;
         end
         e = known_devices;
         known_devices++;
         dev_addr[e] = a; dev_sight[e] = 0; dev_flags[e] = 0;
         dev_power[e] = srdt_pkg::POWER_UNKNOWN; dev_svc_n[e] = 0; dev_name_n[e] = 0;
         oc = srdt_pkg::OC_NEW;
      end
      cur_dev = e; cur_ok = 1;
      dev_last[e] = ss;
      if (dev_sight[e] == 0) dev_avg[e] = ss;
      else dev_avg[e] = 8'((4 * int'(dev_avg[e]) + int'(ss)) / 5);
      if (dev_sight[e] != srdt_pkg::SIGHT_MAX) dev_sight[e]++;
      pay_total = (len < PAY_MAX) ? len : PAY_MAX;
      pos = 0; phase = srdt_pkg::PH_LEN; remaining = 0; ad_type = 0; low_byte = 0;
      return oc;
   endfunction

   function automatic srdt_pkg::outcome_type track_byte(logic [7:0] b);
      int p;
      logic [15:0] uuid;
      bit dup;
      if (!cur_ok || pos >= pay_total) return srdt_pkg::OC_IGNORED;
      p = pos;
      pos++;
      if (phase == srdt_pkg::PH_DONE) return srdt_pkg::OC_IGNORED;
      if (phase == srdt_pkg::PH_LEN) begin
         if (p + 1 >= pay_total || b == 0 || p + b >= pay_total) begin
            phase = srdt_pkg::PH_DONE;
            return srdt_pkg::OC_IGNORED;
         end
         remaining = b - 1;
         phase = srdt_pkg::PH_TYPE;
         return srdt_pkg::OC_USED;
      end
      if (phase == srdt_pkg::PH_TYPE) begin
         ad_type = b;
         if (remaining == 0) phase = srdt_pkg::PH_LEN;
         else if (b == srdt_pkg::AD_FLAGS || b == srdt_pkg::AD_TX_POWER)
            phase = srdt_pkg::PH_FIRST;
         else if (b == srdt_pkg::AD_SVC_PART || b == srdt_pkg::AD_SVC_FULL)
            phase = srdt_pkg::PH_SVC_LO;
         else if ((b == srdt_pkg::AD_NAME_SHORT || b == srdt_pkg::AD_NAME_FULL) &&
                  (dev_name_n[cur_dev] == 0 || b == srdt_pkg::AD_NAME_FULL)) begin
            dev_name_n[cur_dev] = 0;
            phase = srdt_pkg::PH_NAME;
         end else phase = srdt_pkg::PH_SKIP;
         return srdt_pkg::OC_USED;
      end
      case (phase)
         srdt_pkg::PH_FIRST: begin
            if (ad_type == srdt_pkg::AD_FLAGS) dev_flags[cur_dev] = b;
            else dev_power[cur_dev] = b;
            phase = srdt_pkg::PH_SKIP;
         end
         srdt_pkg::PH_SVC_LO: begin
            low_byte = b;
            phase = srdt_pkg::PH_SVC_HI;
         end
         srdt_pkg::PH_SVC_HI: begin
            uuid = {b, low_byte};
            dup = 0;
            for (int k = 0; k < dev_svc_n[cur_dev]; k++)
               if (dev_svc[cur_dev][k] == uuid) dup = 1;
            if (!dup && dev_svc_n[cur_dev] < SLOTS) begin
               dev_svc[cur_dev][dev_svc_n[cur_dev]] = uuid;
               dev_svc_n[cur_dev]++;
            end
            phase = srdt_pkg::PH_SVC_LO;
         end
         srdt_pkg::PH_NAME: if (dev_name_n[cur_dev] < NAME_MAX) dev_name_n[cur_dev]++;
         default: ;
      endcase
      if (remaining > 0) remaining--;
      if (remaining == 0) phase = srdt_pkg::PH_LEN;
      return srdt_pkg::OC_USED;
   endfunction

   function automatic int pause_cycles();
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   // drive one item at the falling edge and hold it until the transfer
   task automatic send_item(bit act, logic [47:0] a, bit at, logic [2:0] ev,
                            logic [7:0] ss, logic [4:0] len, logic [7:0] b);
      int gap;
      srdt_pkg::outcome_type oc;
      gap = pause_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_action = act; req_device_address = a; req_address_type = at;
      req_event_type = ev; req_signal_strength = ss; req_payload_length = len;
      req_payload_byte = b; req_valid = 1;
      do @(posedge clock); while (!req_ready);
      if (act) oc = track_byte(b);
      else oc = track_header(a, ss, len);
      if (oc == srdt_pkg::OC_FULL) n_full++;
      if (oc == srdt_pkg::OC_USED) n_used++;
      pending.push_back(snapshot(oc));
      n_items++;
   endtask

   task automatic send_header(logic [47:0] a, logic [7:0] ss, logic [4:0] len);
      send_item(1'b0, a, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)), ss, len,
                8'($urandom));
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(1'b1, 48'({$urandom, $urandom}), 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)), 8'($urandom), 5'($urandom), b);
   endtask

   // receiver: random stall before each result
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (seen_results != n_results) begin
            seen_results = n_results;
            rx_stall = pause_cycles();
         end
         if (rx_stall == 0) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            rx_stall = rx_stall - 1;
         end
      end
   end

   function automatic void check_field(string what, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
         failed = 1;
      end
   endfunction

   always @(posedge clock) begin
      sighting_type s;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected, outcome %0d", $time, rsp_outcome);
            failed = 1;
         end else begin
            s = pending.pop_front();
            check_field("entry_index", s.idx, rsp_entry_index);
            check_field("outcome", s.oc, rsp_outcome);
            check_field("average_strength", s.avg, rsp_average_strength[7:0]);
            check_field("last_strength", s.last, rsp_last_strength[7:0]);
            check_field("sighting_count", s.sight, rsp_sighting_count);
            check_field("devices_known", s.known, rsp_devices_known);
            check_field("entry_flags", s.flags, rsp_entry_flags);
            check_field("entry_tx_power", s.power, rsp_entry_tx_power[7:0]);
            check_field("service_count", s.svcs, rsp_service_count);
            check_field("name_length", s.name_len, rsp_name_length);
         end
      end
   end

   task automatic test_directed();
      logic [7:0] seq[$];
      quiet = 1;
      send_byte(8'hFF);                              // no header yet
      send_header('1, 8'sd127, 5'd0);
      send_byte(8'h00);                              // past the length
      send_header('0, -8'sd128, 5'd31);
      send_header('0, 8'sd127, 5'd31);               // known, average moves
      seq = '{8'h02, srdt_pkg::AD_FLAGS, 8'hFF, 8'h03, srdt_pkg::AD_TX_POWER, 8'h80,
              8'h55, 8'h05, srdt_pkg::AD_SVC_FULL, 8'h0D, 8'h18, 8'h0D, 8'h18,
              8'h03, srdt_pkg::AD_NAME_SHORT, 8'h61, 8'h62, 8'h01, srdt_pkg::AD_NAME_FULL,
              8'h04, srdt_pkg::AD_SVC_PART, 8'hAA, 8'h55, 8'h77, 8'h04, 8'h01};
      quiet = 0;
      foreach (seq[i]) send_byte(seq[i]);
      send_header('0, 8'sd0, 5'd5);
      send_byte(8'h00);                              // zero length stops parsing
   endtask

   // distinct devices until the table runs over
   task automatic test_table_fill();
      logic [47:0] a;
      for (int i = 0; i < ENTRIES + 8; i++) begin
         a = 48'({$urandom, $urandom});
         addr_pool.push_back(a);
         send_header(a, 8'($urandom), 5'($urandom_range(0, 3)));
         if (i % 9 == 0) send_byte(8'($urandom));
      end
   endtask

   task automatic send_report();
      logic [7:0] body[$];
      logic [7:0] types[8] = '{srdt_pkg::AD_FLAGS, srdt_pkg::AD_TX_POWER,
                              srdt_pkg::AD_SVC_PART, srdt_pkg::AD_SVC_FULL,
                              srdt_pkg::AD_NAME_SHORT, srdt_pkg::AD_NAME_FULL,
                              8'hFF, 8'h16};
      int len, dlen, room, extra, style;
      logic [47:0] a;
      if ($urandom_range(0, 9) == 0) a = 48'({$urandom, $urandom});
      else a = addr_pool[$urandom_range(0, 2 * ENTRIES / 3)];
      len = $urandom_range(0, 31);
      style = $urandom_range(0, 9);
      while (body.size() < len) begin
         room = len - body.size();
         dlen = (room > 2) ? $urandom_range(0, room - 2) : 0;
         if ($urandom_range(0, 3) == 0) dlen = dlen % 5;
         body.push_back(8'(style == 0 ? $urandom : dlen + 1));
         body.push_back(types[$urandom_range(0, 7)]);
         repeat (dlen) body.push_back(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                                    : $urandom));
      end
      extra = (style == 1) ? $urandom_range(1, 3) : 0;
      if (style == 2) body = body[0:$urandom_range(0, body.size())];
      send_header(a, 8'($urandom), 5'(len));
      foreach (body[i]) if (i < len || extra > 0) send_byte(body[i]);
      repeat (extra) send_byte(8'($urandom));
   endtask

   task automatic test_random_reports();
      int stretch;
      while (n_items < 1550) begin
         stretch = $urandom_range(0, 7);
         quiet = (stretch == 0);
         send_report();
      end
      quiet = 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_table_fill();
      test_random_reports();
      @(negedge clock);
      req_valid = 0;
      for (int w = 0; w < 20000 && pending.size() != 0; w++) @(posedge clock);
      repeat (100) @(posedge clock);
      if (pending.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending.size());
         failed = 1;
      end
      $display("%0d items sent, %0d results checked", n_items, n_results);
      $display("%0d parser bytes used, %0d reports refused on a full table", n_used, n_full);
      if (!failed) $display("scan_report_device_table_top regression: pass");
      else $display("scan_report_device_table_top regression: fail");
      $finish;
   end

   initial begin
      #8ms;
      $display("scan_report_device_table_top regression: fail");
      $finish;
   end

endmodule
